// ===== hdl/pdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types and constants of the deadband PID controller.
// ----------------------------------------------------------------------------
package pdb_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_KP             = 3'd0,
      REG_KI             = 3'd1,
      REG_KD             = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_I_TERM_LIMIT   = 3'd4,
      REG_OUTPUT_LIMIT   = 3'd5,
      REG_DEADBAND       = 3'd6
   } csr_index_type;

   localparam logic [23:0] IntegralLimitReset = 24'd10000;
   localparam logic [15:0] ITermLimitReset    = 16'd8000;
   localparam logic [15:0] OutputLimitReset   = 16'd16000;

   typedef struct packed {
      logic signed [23:0] kp;
      logic signed [23:0] ki;
      logic signed [23:0] kd;
      logic [23:0]        integral_limit;
      logic [15:0]        i_term_limit;
      logic [15:0]        output_limit;
      logic [15:0]        deadband;
   } cfg_type;

endpackage

// ===== hdl/positional_pid_with_deadband.sv =====
`timescale 1ns / 1ps
// an accepted req transaction passes through the s1, s2, s3 and rsp registers to rsp_tvalid
// throughput: one transaction per cycle while rsp_tready does not stall the pipeline, set by the error sum update
// four pipeline stages, each with its own valid bit, so bubbles are squeezed out
// reset: synchronous, active high; clears valids, error sum and previous error,
// and loads the register defaults
// ----------------------------------------------------------------------------
// positional_pid_with_deadband
// Positional PID controller with deadband, integral and output clamps.
// ----------------------------------------------------------------------------
module positional_pid_with_deadband (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // target[15:0], actual[31:16]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // drive[16:0], zero pad[23:17]
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdb_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pdb_pkg::CsrDataWidth-1:0]    csr_data
);

   pdb_pkg::cfg_type cfg;

   pdb_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // ---------------- handshake chain ----------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, rsp_rdy;
   logic req_fire;

   assign rsp_rdy    = !rsp_v_ff || rsp_tready;
   assign s3_rdy     = !s3_v_ff || rsp_rdy;
   assign s2_rdy     = !s2_v_ff || s3_rdy;
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy;
   assign req_fire   = req_tvalid && s1_rdy;
   assign rsp_tvalid = rsp_v_ff;

   // ---------------- stage 1: error, deadband, error sum ----------------
   logic signed [15:0] tgt, act;
   logic signed [16:0] err_raw, err_db;
   logic signed [17:0] err_ext, db18, ndb18, diff;
   logic signed [25:0] sum_raw, lim26, nlim26;
   logic signed [24:0] sum_clamp;
   logic signed [24:0] error_sum_ff;
   logic signed [16:0] prev_err_ff;
   logic signed [16:0] s1_err_ff;
   logic signed [17:0] s1_diff_ff;
   logic signed [24:0] s1_sum_ff;

   assign tgt     = signed'(req_tdata[15:0]);
   assign act     = signed'(req_tdata[31:16]);
   assign err_raw = {tgt[15], tgt} - {act[15], act};
   assign err_ext = {err_raw[16], err_raw};
   assign db18    = signed'({2'b00, cfg.deadband});
   assign ndb18   = -db18;
   assign err_db  = (err_ext > ndb18 && err_ext < db18) ? 17'sd0 : err_raw;

   assign sum_raw = {error_sum_ff[24], error_sum_ff} + {{9{err_db[16]}}, err_db};
   assign lim26   = signed'({2'b00, cfg.integral_limit});
   assign nlim26  = -lim26;

   always_comb begin
      if (sum_raw > lim26) begin
         sum_clamp = lim26[24:0];
      end else if (sum_raw < nlim26) begin
         sum_clamp = nlim26[24:0];
      end else begin
         sum_clamp = sum_raw[24:0];
      end
   end

   assign diff = {err_db[16], err_db} - {prev_err_ff[16], prev_err_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else if (req_fire) begin
         error_sum_ff <= sum_clamp;
         prev_err_ff  <= err_db;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_err_ff  <= err_db;
         s1_diff_ff <= diff;
         s1_sum_ff  <= sum_clamp;
      end
   end

   // ---------------- stage 2: gain products ----------------
   logic signed [40:0] p_prod;
   logic signed [48:0] i_prod;
   logic signed [41:0] d_prod;
   logic signed [40:0] s2_p_ff;
   logic signed [48:0] s2_i_ff;
   logic signed [41:0] s2_d_ff;

   // error_sum already holds the value after this transaction's update
   assign p_prod = s1_err_ff * cfg.kp;
   assign i_prod = s1_sum_ff * cfg.ki;
   assign d_prod = s1_diff_ff * cfg.kd;

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_p_ff <= p_prod;
         s2_i_ff <= i_prod;
         s2_d_ff <= d_prod;
      end
   end

   // ---------------- stage 3: floor shift, I clamp, P+D ----------------
   logic signed [32:0] p_sh;
   logic signed [40:0] i_sh, ilim41, nilim41;
   logic signed [33:0] d_sh;
   logic signed [16:0] i_clamp;
   logic signed [34:0] pd_sum;
   logic signed [16:0] s3_i_ff;
   logic signed [34:0] s3_pd_ff;

   // arithmetic shift right by 8 rounds toward minus infinity
   assign p_sh    = s2_p_ff[40:8];
   assign i_sh    = s2_i_ff[48:8];
   assign d_sh    = s2_d_ff[41:8];
   assign ilim41  = signed'({25'd0, cfg.i_term_limit});
   assign nilim41 = -ilim41;

   always_comb begin
      if (i_sh > ilim41) begin
         i_clamp = ilim41[16:0];
      end else if (i_sh < nilim41) begin
         i_clamp = nilim41[16:0];
      end else begin
         i_clamp = i_sh[16:0];
      end
   end

   assign pd_sum = {{2{p_sh[32]}}, p_sh} + {d_sh[33], d_sh};

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_i_ff  <= i_clamp;
         s3_pd_ff <= pd_sum;
      end
   end

   // ---------------- stage 4: total and output clamp ----------------
   logic signed [35:0] total, olim36, nolim36;
   logic signed [16:0] drive_clamp;
   logic signed [16:0] rsp_drive_ff;

   assign total   = {s3_pd_ff[34], s3_pd_ff} + {{19{s3_i_ff[16]}}, s3_i_ff};
   assign olim36  = signed'({20'd0, cfg.output_limit});
   assign nolim36 = -olim36;

   always_comb begin
      if (total > olim36) begin
         drive_clamp = olim36[16:0];
      end else if (total < nolim36) begin
         drive_clamp = nolim36[16:0];
      end else begin
         drive_clamp = total[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_rdy) begin
         rsp_drive_ff <= drive_clamp;
      end
   end

   assign rsp_tdata = {7'd0, rsp_drive_ff};

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= req_tvalid;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_rdy) begin
            s3_v_ff <= s2_v_ff;
         end
         if (rsp_rdy) begin
            rsp_v_ff <= s3_v_ff;
         end
      end
   end

`ifndef SYNTH
   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_v_ff)
      else $error("accepted transaction did not reach stage 1");

   a_blocked_s3_holds : assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && !rsp_rdy) |=> (s3_v_ff && $stable(s3_pd_ff) && $stable(s3_i_ff)))
      else $error("blocked stage 3 lost its transaction");

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> (!rsp_v_ff && !s1_v_ff && error_sum_ff == 25'sd0))
      else $error("reset did not clear pipeline and error sum");
`endif

endmodule

// ===== hdl/pdb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_regs
// Configuration register file: gains, clamp limits and deadband.
// ----------------------------------------------------------------------------
module pdb_regs (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pdb_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [pdb_pkg::CsrDataWidth-1:0]       csr_data,
   output pdb_pkg::cfg_type                       cfg
);

   pdb_pkg::cfg_type cfg_ff;
   pdb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pdb_pkg::csr_index_type'(csr_index))
            pdb_pkg::REG_KP:             cfg_in.kp             = signed'(csr_data);
            pdb_pkg::REG_KI:             cfg_in.ki             = signed'(csr_data);
            pdb_pkg::REG_KD:             cfg_in.kd             = signed'(csr_data);
            pdb_pkg::REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data;
            pdb_pkg::REG_I_TERM_LIMIT:   cfg_in.i_term_limit   = csr_data[15:0];
            pdb_pkg::REG_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_data[15:0];
            pdb_pkg::REG_DEADBAND:       cfg_in.deadband       = csr_data[15:0];
            // unknown index is ignored
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp             <= '0;
         cfg_ff.ki             <= '0;
         cfg_ff.kd             <= '0;
         cfg_ff.integral_limit <= pdb_pkg::IntegralLimitReset;
         cfg_ff.i_term_limit   <= pdb_pkg::ITermLimitReset;
         cfg_ff.output_limit   <= pdb_pkg::OutputLimitReset;
         cfg_ff.deadband       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
